### rtl/cs_pkg.sv
// Shared types and constants of the counting sort block.
package cs_pkg;

	// Width of a key field on both streams.
	localparam int KEY_W = 10;

	// Number of distinct key values that the key field can carry.
	localparam int KEY_SPAN = 1 << KEY_W;

	// Width of the tdata bus: the key filled up to whole bytes.
	localparam int TDATA_W = ((KEY_W + 7) / 8) * 8;

	// One sorted result beat waiting for the output stream.
	typedef struct packed {
		logic             last;
		logic [KEY_W-1:0] key;
	} beat_t;

endpackage

### rtl/cs_hist_ram.sv
// Histogram memory: one write port and one registered read port.
module cs_hist_ram #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int DW    = 7
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	// A read at the address being written returns the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/cs_out_buf.sv
// Two-entry output buffer that decouples the scan from the result stream.
module cs_out_buf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  cs_pkg::beat_t din,
	output logic          full,
	output logic          m_valid,
	input  logic          m_ready,
	output cs_pkg::beat_t m_beat
);

	logic [1:0]    count_q;
	cs_pkg::beat_t ent0_q;
	cs_pkg::beat_t ent1_q;
	logic          pop;
	logic          do_push;

	assign pop     = m_valid && m_ready;
	assign do_push = push && (count_q != 2'd2);
	assign full    = (count_q == 2'd2);
	assign m_valid = (count_q != 2'd0);
	assign m_beat  = ent0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			count_q <= count_q + {1'b0, do_push} - {1'b0, pop};
		end
	end

	// Entry 0 is always the head; entry 1 moves up when the head leaves.
	always_ff @(posedge clk) begin
		unique case (count_q)
			2'd0: begin
				if (do_push) begin
					ent0_q <= din;
				end
			end
			2'd1: begin
				if (do_push && pop) begin
					ent0_q <= din;
				end else if (do_push) begin
					ent1_q <= din;
				end
			end
			2'd2: begin
				if (pop) begin
					ent0_q <= ent1_q;
				end
			end
			default: begin
				ent0_q <= ent0_q;
			end
		endcase
	end

`ifndef SYNTH
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("output buffer count out of range");

	a_full_holds_head: assert property (@(posedge clk) disable iff (!arst_n)
		(full && !pop) |=> (count_q == 2'd2 && $stable(ent0_q)))
		else $error("full buffer lost or changed its head");

	a_pop_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd1 && pop && !do_push) |=> !m_valid)
		else $error("buffer still valid after its only entry left");
`endif

endmodule

### rtl/counting_sort.sv
// Top level of the counting sort block: control, histogram update and scan.
//
//   channel   | signals                    | carries
//   ----------+----------------------------+------------------------------------
//   s_axis    | tvalid tready tdata tlast  | one key per beat, tlast closes set
//   m_axis    | tvalid tready tdata tlast  | sorted keys, tlast on final beat
//
// Reset starts a clearing pass that zeroes one histogram entry per cycle over min(KEY_RANGE,
// 1024) entries, with no beat taken. Loading takes one key beat per cycle: each key is read,
// incremented from the registered read data and written back, and a write to the key just
// before is forwarded. After the tlast beat a drain state lets the final write land, then, if
// any key was counted, the scan walks keys from zero up to the largest loaded key through read,
// fetch and emit states, clearing each entry it reads; input is held off meanwhile. A stalled
// output stalls the scan once the two-beat output buffer is full.
module counting_sort #(
	parameter int MAX_ITEMS = 64,
	parameter int KEY_RANGE = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [cs_pkg::TDATA_W-1:0] s_axis_tdata,  // [9:0] key
	input  logic                       s_axis_tlast,  // last_key
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	output logic [cs_pkg::TDATA_W-1:0] m_axis_tdata,  // [9:0] sorted_key
	output logic                       m_axis_tlast   // last_out
);

	// Only keys below both the key range and the key field's span get entries.
	localparam int DEPTH = (KEY_RANGE < cs_pkg::KEY_SPAN) ? KEY_RANGE : cs_pkg::KEY_SPAN;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(MAX_ITEMS + 1);

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,  // zero the histogram after reset
		ST_LOAD  = 6'b000010,  // take key beats
		ST_DRAIN = 6'b000100,  // let the final histogram write land
		ST_READ  = 6'b001000,  // read the entry at the scan address
		ST_FETCH = 6'b010000,  // take its count and clear the entry
		ST_EMIT  = 6'b100000   // send one beat per counted key
	} state_t;

	state_t state_q;

	logic [cs_pkg::KEY_W-1:0] key_in;
	logic                     in_acc;
	logic                     keep_key;

	// Count of kept keys in the current set; during the scan it counts down
	// the beats still owed, so it is back at zero when the scan ends.
	logic [CNT_W-1:0] items_q;
	logic [AW-1:0]    scan_q;
	logic [CNT_W-1:0] cnt_q;

	// Increment stage: key address whose read is coming back this cycle.
	logic          incr_vld_s1;
	logic [AW-1:0] incr_addr_s1;

	// Last histogram increment, forwarded to a back-to-back repeat of a key.
	logic             fwd_vld_q;
	logic [AW-1:0]    fwd_addr_q;
	logic [CNT_W-1:0] fwd_data_q;

	logic [CNT_W-1:0] old_cnt;
	logic [CNT_W-1:0] inc_cnt;

	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [CNT_W-1:0] ram_wdata;
	logic [AW-1:0]    ram_raddr;
	logic [CNT_W-1:0] ram_rdata;

	logic          push;
	logic          buf_full;
	cs_pkg::beat_t push_beat;
	cs_pkg::beat_t out_beat;

	assign key_in        = s_axis_tdata[cs_pkg::KEY_W-1:0];
	assign s_axis_tready = (state_q == ST_LOAD);
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	// Keys out of range, and keys past a full set, are dropped uncounted.
	assign keep_key = (32'(key_in) < KEY_RANGE) && (items_q < CNT_W'(MAX_ITEMS));

	assign old_cnt = (fwd_vld_q && (fwd_addr_q == incr_addr_s1)) ? fwd_data_q : ram_rdata;
	assign inc_cnt = old_cnt + CNT_W'(1);

	// Memory ports: the increment stage owns the write port while loading
	// and draining, the clearing pass and the scan own it otherwise.
	always_comb begin
		ram_raddr = (state_q == ST_LOAD) ? key_in[AW-1:0] : scan_q;
		ram_we    = 1'b0;
		ram_waddr = scan_q;
		ram_wdata = '0;
		priority if (incr_vld_s1) begin
			ram_we    = 1'b1;
			ram_waddr = incr_addr_s1;
			ram_wdata = inc_cnt;
		end else if (state_q == ST_CLEAR || state_q == ST_FETCH) begin
			ram_we = 1'b1;
		end
	end

	cs_hist_ram #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.DW    (CNT_W)
	) u_hist (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			incr_vld_s1 <= 1'b0;
			fwd_vld_q   <= 1'b0;
		end else begin
			incr_vld_s1 <= in_acc && keep_key;
			fwd_vld_q   <= incr_vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		incr_addr_s1 <= key_in[AW-1:0];
		fwd_addr_q   <= incr_addr_s1;
		fwd_data_q   <= inc_cnt;
	end

	// Result beats: the last one is the beat that settles the final owed key.
	assign push           = (state_q == ST_EMIT) && (cnt_q != '0) && !buf_full;
	assign push_beat.key  = cs_pkg::KEY_W'(scan_q);
	assign push_beat.last = (items_q == CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			items_q <= '0;
			scan_q  <= '0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					if (scan_q == AW'(DEPTH - 1)) begin
						scan_q  <= '0;
						state_q <= ST_LOAD;
					end else begin
						scan_q <= scan_q + AW'(1);
					end
				end
				ST_LOAD: begin
					if (in_acc) begin
						if (keep_key) begin
							items_q <= items_q + CNT_W'(1);
						end
						if (s_axis_tlast) begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					// An empty set has nothing to scan or clear.
					state_q <= (items_q == '0) ? ST_LOAD : ST_READ;
				end
				ST_READ: begin
					state_q <= ST_FETCH;
				end
				ST_FETCH: begin
					cnt_q   <= ram_rdata;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (cnt_q == '0) begin
						if (items_q == '0) begin
							scan_q  <= '0;
							state_q <= ST_LOAD;
						end else begin
							scan_q  <= scan_q + AW'(1);
							state_q <= ST_READ;
						end
					end else if (push) begin
						cnt_q   <= cnt_q - CNT_W'(1);
						items_q <= items_q - CNT_W'(1);
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	cs_out_buf u_obuf (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.din     (push_beat),
		.full    (buf_full),
		.m_valid (m_axis_tvalid),
		.m_ready (m_axis_tready),
		.m_beat  (out_beat)
	);

	assign m_axis_tdata = cs_pkg::TDATA_W'(out_beat.key);
	assign m_axis_tlast = out_beat.last;

`ifndef SYNTH
	a_items_bound: assert property (@(posedge clk) disable iff (!arst_n)
		items_q <= CNT_W'(MAX_ITEMS))
		else $error("set count exceeds the item limit");

	a_incr_window: assert property (@(posedge clk) disable iff (!arst_n)
		incr_vld_s1 |-> (state_q == ST_LOAD || state_q == ST_DRAIN))
		else $error("histogram increment overlaps the scan or clearing pass");

	a_load_starts_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD && $past(state_q) != ST_LOAD) |-> (items_q == '0))
		else $error("a new set starts with a nonzero count");

	a_last_ends_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(push && push_beat.last) |=> (items_q == '0))
		else $error("beats still owed after the final beat");

	a_no_input_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && cnt_q != '0) |-> (items_q != '0))
		else $error("scan holds a count with no beats owed");
`endif

endmodule
